[rtl/rycc_pkg.sv]
// rycc_pkg: shared types, constants and helpers of the rgb to ycbcr 4:2:0 converter
// used by rycc_color_math and rgb_to_ycbcr420_converter_unit; no dependencies
`default_nettype none

package rycc_pkg;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // plane coordinate width
    localparam int POS_W = 12;

    // fixed point Q16 coefficients
    localparam int Q      = 16;
    localparam int HALF   = 1 << (Q - 1);
    localparam int C_Y_R  = 11966;
    localparam int C_Y_G  = 40254;
    localparam int C_Y_B  = 4064;
    localparam int C_U_R  = -6595;
    localparam int C_U_G  = -22190;
    localparam int C_U_B  = 28782;
    localparam int C_V_R  = 28782;
    localparam int C_V_G  = -26145;
    localparam int C_V_B  = -2637;
    localparam int C_Y_OFFSET = (16 << Q) + HALF;
    localparam int C_C_OFFSET = (128 << Q) + HALF;

    // width of the signed chroma accumulation
    localparam int ACC_W = 29;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic             is_chroma;
        logic [7:0]       luma;
        logic [7:0]       cb;
        logic [7:0]       cr;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last_of_run;
    } t_result;

    // horizontal pair sums, packed as b | g << 9 | r << 18
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } t_pair_sum;

    // per item position and chroma flag that travel with the data
    typedef struct packed {
        logic             has_chroma;
        logic [POS_W-1:0] luma_x;
        logic [POS_W-1:0] luma_y;
        logic [POS_W-1:0] chroma_x;
        logic [POS_W-1:0] chroma_y;
    } t_side;

    // contents of the first pipeline stage
    typedef struct packed {
        t_pixel    pixel;
        t_pair_sum pair;
        logic      row_odd;
        t_side     side;
    } t_stage_a;

    // stage load strobes from the pipeline control
    typedef struct packed {
        logic load_b;
        logic load_c;
    } t_stage_ctl;

    // floor shift by Q then clamp to 0..255
    function automatic logic [7:0] clamp_q16(input logic signed [ACC_W-1:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v[ACC_W-1:Q] > (ACC_W - Q)'(255)) begin
            res = 8'd255;
        end else begin
            res = v[Q+7:Q];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/rgb_to_ycbcr420_converter_unit.sv]
// rgb_to_ycbcr420_converter_unit: top level, pixel counters, line store and result sequencing
// depends on rycc_pkg and rycc_color_math
`default_nettype none

// Converts a raster stream of 8-bit RGB pixels into BT.709 limited-range luma for every
// pixel and one Cb/Cr pair for every 2x2 block (4:2:0). A pixel transaction is taken in
// every clock while the pipeline has room; it passes three register stages (line store
// read, products, sums and clamp) before its luma result is offered. The output port
// carries one result per clock while i_out_ready is high: the pixel that closes a 2x2
// block gives its luma result followed by the block's chroma result, marked with
// is_chroma, and last_of_run flags the final result of each pixel. With even frame
// dimensions four pixels therefore give five results and the output port limits the
// sustained rate; a stalled output fills the stages and then holds o_in_ready low. The
// horizontal pair sums of each even row sit in a line store of (MAX_WIDTH+1)/2 entries
// of 27 bits with one write and one registered read per cycle; an even row writes an
// entry and the following odd row reads it back in a later cycle, so no forwarding is
// needed. The line store has no reset and needs no clearing. An odd last column or row
// is paired with itself. The user must write frame width and height through the
// configuration port only while the block is idle; the block itself does not enforce
// this. Zero acts as one, values above the maximum act as the maximum, and every write
// restarts the frame at column 0, row 0. After the last pixel of a frame the counters
// wrap and the next frame begins.
module rgb_to_ycbcr420_converter_unit #(
    parameter int MAX_WIDTH  = rycc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rycc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel input
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire rycc_pkg::t_pixel               i_in_data,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output rycc_pkg::t_result                   o_out_data,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rycc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rycc_pkg::CFG_W-1:0]     i_cfg_data
);
    import rycc_pkg::*;

    // counter and line store geometry
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int WB         = CW + 1;
    localparam int HB         = RW + 1;
    localparam int WDW        = (WB > CFG_W) ? WB : CFG_W;
    localparam int HDW        = (HB > CFG_W) ? HB : CFG_W;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // frame geometry, already limited to 1..max
    logic [WB-1:0] r_w;
    logic [HB-1:0] r_h;
    logic [WDW-1:0] cfg_w_ext;
    logic [HDW-1:0] cfg_h_ext;
    logic [WB-1:0]  eff_w;
    logic [HB-1:0]  eff_h;

    // raster position and held even column pixel
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_pixel        r_held;

    // pipeline control
    logic r_a_valid, r_b_valid, r_c_valid, r_phase;
    logic in_acc, cfg_acc, out_acc;
    logic c_done, free_c, free_b, free_a;
    t_stage_ctl ctl;

    // current pixel decode
    logic      col_last, row_last, col_end, row_end;
    t_pixel    p0;
    t_pair_sum pair;
    t_stage_a  stage_in, r_stage_a;

    // line store
    t_pair_sum       line_mem [LINE_DEPTH];
    t_pair_sum       r_top;
    logic [IDX_W-1:0] line_idx;
    logic            line_wr, line_rd;

    // math results
    t_side      side_c;
    logic [7:0] luma_c, cb_c, cr_c;

    //------------------------------------------------------------------
    // configuration: limit to 1..max on write
    //------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_w_ext = WDW'(i_cfg_data);
        cfg_h_ext = HDW'(i_cfg_data);
        if (cfg_w_ext == '0) begin
            eff_w = WB'(1);
        end else if (cfg_w_ext > WDW'(MAX_WIDTH)) begin
            eff_w = WB'(MAX_WIDTH);
        end else begin
            eff_w = WB'(cfg_w_ext);
        end
        if (cfg_h_ext == '0) begin
            eff_h = HB'(1);
        end else if (cfg_h_ext > HDW'(MAX_HEIGHT)) begin
            eff_h = HB'(MAX_HEIGHT);
        end else begin
            eff_h = HB'(cfg_h_ext);
        end
    end

    //------------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or when it drains
    //------------------------------------------------------------------
    // the output stage holds a pixel until its luma and, if any, chroma result are taken
    assign c_done      = r_c_valid && i_out_ready && (r_phase || !side_c.has_chroma);
    assign free_c      = !r_c_valid || c_done;
    assign free_b      = !r_b_valid || free_c;
    assign free_a      = !r_a_valid || free_b;
    assign ctl.load_b  = r_a_valid && free_b;
    assign ctl.load_c  = r_b_valid && free_c;
    assign o_in_ready  = free_a;
    assign in_acc      = i_in_valid && free_a;
    assign o_out_valid = r_c_valid;
    assign out_acc     = r_c_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (ctl.load_b) begin
                r_a_valid <= 1'b0;
            end
            if (ctl.load_b) begin
                r_b_valid <= 1'b1;
            end else if (ctl.load_c) begin
                r_b_valid <= 1'b0;
            end
            if (ctl.load_c) begin
                r_c_valid <= 1'b1;
            end else if (c_done) begin
                r_c_valid <= 1'b0;
            end
            // second result of a block closing pixel is the chroma transaction
            if (out_acc) begin
                r_phase <= !c_done;
            end
        end
    end

    //------------------------------------------------------------------
    // pixel decode at acceptance
    //------------------------------------------------------------------
    always_comb begin
        col_last = ({1'b0, r_col} + WB'(1)) >= r_w;
        row_last = ({1'b0, r_row} + HB'(1)) >= r_h;
        col_end  = r_col[0] || col_last;
        row_end  = r_row[0] || row_last;

        // odd last column pairs with itself
        p0         = r_col[0] ? r_held : i_in_data;
        pair.red   = 9'(p0.red)   + 9'(i_in_data.red);
        pair.green = 9'(p0.green) + 9'(i_in_data.green);
        pair.blue  = 9'(p0.blue)  + 9'(i_in_data.blue);

        line_idx = IDX_W'(r_col >> 1);
        line_wr  = in_acc && col_end && !row_end;
        line_rd  = in_acc && col_end && row_end && r_row[0];

        stage_in.pixel           = i_in_data;
        stage_in.pair            = pair;
        stage_in.row_odd         = r_row[0];
        stage_in.side.has_chroma = col_end && row_end;
        stage_in.side.luma_x     = POS_W'(r_col);
        stage_in.side.luma_y     = POS_W'(r_row);
        stage_in.side.chroma_x   = POS_W'(r_col >> 1);
        stage_in.side.chroma_y   = POS_W'(r_row >> 1);

        // raster advance with wrap at frame end
        n_col = r_col;
        n_row = r_row;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WB'(1);
            r_h    <= HB'(1);
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_w <= eff_w;
                REG_FRAME_HEIGHT: r_h <= eff_h;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!col_end) begin
                r_held <= i_in_data;
            end
        end
    end

    // first stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stage_a <= stage_in;
        end
    end

    //------------------------------------------------------------------
    // line store of even row pair sums
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (line_wr) begin
            line_mem[line_idx] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_rd) begin
            r_top <= line_mem[line_idx];
        end
    end

    //------------------------------------------------------------------
    // color matrix
    //------------------------------------------------------------------
    rycc_color_math u_math (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_stage (r_stage_a),
        .i_top   (r_top),
        .o_side  (side_c),
        .o_luma  (luma_c),
        .o_cb    (cb_c),
        .o_cr    (cr_c)
    );

    //------------------------------------------------------------------
    // result select: luma transaction first, then chroma when the block closes
    //------------------------------------------------------------------
    always_comb begin
        if (r_phase) begin
            o_out_data.is_chroma   = 1'b1;
            o_out_data.luma        = 8'd0;
            o_out_data.cb          = cb_c;
            o_out_data.cr          = cr_c;
            o_out_data.pos_x       = side_c.chroma_x;
            o_out_data.pos_y       = side_c.chroma_y;
            o_out_data.last_of_run = 1'b1;
        end else begin
            o_out_data.is_chroma   = 1'b0;
            o_out_data.luma        = luma_c;
            o_out_data.cb          = 8'd0;
            o_out_data.cr          = 8'd0;
            o_out_data.pos_x       = side_c.luma_x;
            o_out_data.pos_y       = side_c.luma_y;
            o_out_data.last_of_run = !side_c.has_chroma;
        end
    end

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    // chroma phase only for a held pixel that closes a block
    a_phase_has_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_c_valid && side_c.has_chroma))
        else $error("chroma phase without a block closing pixel");

    // a taken luma transaction of a block closing pixel is followed by its chroma
    a_chroma_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !r_phase && side_c.has_chroma) |=> (o_out_valid && r_phase))
        else $error("chroma transaction lost after luma");

    // line store is never written and read by the same pixel
    a_line_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(line_wr && line_rd))
        else $error("line store written and read in one cycle");

    // raster position stays inside the frame
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < r_w) && ({1'b0, r_row} < r_h))
        else $error("raster position outside frame");

    // a configuration write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_col == '0 && r_row == '0))
        else $error("frame not restarted after configuration write");

endmodule

`default_nettype wire

[rtl/rycc_color_math.sv]
// rycc_color_math: two stage color matrix, products then sums, rounding and clamp
// depends on rycc_pkg
`default_nettype none

module rycc_color_math (
    input  wire logic                 i_clk,
    input  wire rycc_pkg::t_stage_ctl i_ctl,
    input  wire rycc_pkg::t_stage_a   i_stage,
    input  wire rycc_pkg::t_pair_sum  i_top,
    output rycc_pkg::t_side           o_side,
    output logic [7:0]                o_luma,
    output logic [7:0]                o_cb,
    output logic [7:0]                o_cr
);
    import rycc_pkg::*;

    t_pair_sum top_sel;
    logic [9:0] sum_r, sum_g, sum_b;

    // product stage
    t_side                    r_side_b;
    logic [23:0]              r_py_r, r_py_g, r_py_b;
    logic signed [26:0]       r_pu_r, r_pu_g, r_pu_b;
    logic signed [26:0]       r_pv_r, r_pv_g, r_pv_b;

    // sum stage
    logic [24:0]              y_sum;
    logic signed [ACC_W-1:0]  u_sum, v_sum, u_q, v_q, u_off, v_off;

    t_side                    r_side_c;
    logic [7:0]               r_luma, r_cb, r_cr;

    // last row of an odd height frame pairs with itself
    always_comb begin
        top_sel = i_stage.row_odd ? i_top : i_stage.pair;
        sum_r   = 10'(top_sel.red)   + 10'(i_stage.pair.red);
        sum_g   = 10'(top_sel.green) + 10'(i_stage.pair.green);
        sum_b   = 10'(top_sel.blue)  + 10'(i_stage.pair.blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_b) begin
            r_side_b <= i_stage.side;
            r_py_r   <= 24'(i_stage.pixel.red   * C_Y_R);
            r_py_g   <= 24'(i_stage.pixel.green * C_Y_G);
            r_py_b   <= 24'(i_stage.pixel.blue  * C_Y_B);
            r_pu_r   <= 27'(signed'({1'b0, sum_r}) * C_U_R);
            r_pu_g   <= 27'(signed'({1'b0, sum_g}) * C_U_G);
            r_pu_b   <= 27'(signed'({1'b0, sum_b}) * C_U_B);
            r_pv_r   <= 27'(signed'({1'b0, sum_r}) * C_V_R);
            r_pv_g   <= 27'(signed'({1'b0, sum_g}) * C_V_G);
            r_pv_b   <= 27'(signed'({1'b0, sum_b}) * C_V_B);
        end
    end

    // divide by four toward zero, then offset
    always_comb begin
        y_sum = 25'(r_py_r) + 25'(r_py_g) + 25'(r_py_b) + 25'(C_Y_OFFSET);
        u_sum = ACC_W'(r_pu_r) + ACC_W'(r_pu_g) + ACC_W'(r_pu_b);
        v_sum = ACC_W'(r_pv_r) + ACC_W'(r_pv_g) + ACC_W'(r_pv_b);
        u_q   = (u_sum + (u_sum[ACC_W-1] ? ACC_W'(signed'(3)) : ACC_W'(signed'(0)))) >>> 2;
        v_q   = (v_sum + (v_sum[ACC_W-1] ? ACC_W'(signed'(3)) : ACC_W'(signed'(0)))) >>> 2;
        u_off = u_q + ACC_W'(C_C_OFFSET);
        v_off = v_q + ACC_W'(C_C_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_c) begin
            r_side_c <= r_side_b;
            r_luma   <= clamp_q16(ACC_W'(y_sum));
            r_cb     <= clamp_q16(u_off);
            r_cr     <= clamp_q16(v_off);
        end
    end

    assign o_side = r_side_c;
    assign o_luma = r_luma;
    assign o_cb   = r_cb;
    assign o_cr   = r_cr;

endmodule

`default_nettype wire
